// File: rtl/core/nmea_pkg.sv
package nmea_pkg;

	localparam int MAX_FIELDS = 16;
	localparam int FIELD_W = $clog2(MAX_FIELDS);
	localparam logic [19:0] SAT_MAX = 20'd999999;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT = 8'h2E;

	localparam logic [1:0] HK_NONE = 2'd0;
	localparam logic [1:0] HK_GGA = 2'd1;
	localparam logic [1:0] HK_VTG = 2'd2;
	localparam logic [1:0] HK_MATCH = 2'd3;

	localparam logic [1:0] CK_ACC = 2'd0;
	localparam logic [1:0] CK_HI = 2'd1;
	localparam logic [1:0] CK_LO = 2'd2;
	localparam logic [1:0] CK_DONE = 2'd3;

	localparam logic [1:0] NUM_INT = 2'd0;
	localparam logic [1:0] NUM_F1 = 2'd1;
	localparam logic [1:0] NUM_F2 = 2'd2;
	localparam logic [1:0] NUM_END = 2'd3;

	localparam logic [1:0] KIND_REJ = 2'd0;
	localparam logic [1:0] KIND_FIX = 2'd1;
	localparam logic [1:0] KIND_VTG = 2'd2;
	localparam logic [1:0] KIND_NOFIX = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] lat;
		logic [31:0] lon;
		logic [7:0]  quality;
		logic [19:0] course;
		logic [19:0] speed;
	} result_t;

	function automatic logic [31:0] lat_weight(input logic [7:0] k);
		case (k)
			8'd0: lat_weight = 32'd10000000;
			8'd1: lat_weight = 32'd1000000;
			8'd2: lat_weight = 32'd100000;
			8'd3: lat_weight = 32'd10000;
			8'd5: lat_weight = 32'd1000;
			8'd6: lat_weight = 32'd100;
			8'd7: lat_weight = 32'd10;
			8'd8: lat_weight = 32'd1;
			default: lat_weight = 32'd0;
		endcase
	endfunction

	function automatic logic [31:0] lon_weight(input logic [7:0] k);
		case (k)
			8'd0: lon_weight = 32'd100000000;
			8'd1: lon_weight = 32'd10000000;
			8'd2: lon_weight = 32'd1000000;
			8'd3: lon_weight = 32'd100000;
			8'd4: lon_weight = 32'd10000;
			8'd6: lon_weight = 32'd1000;
			8'd7: lon_weight = 32'd100;
			8'd8: lon_weight = 32'd10;
			8'd9: lon_weight = 32'd1;
			default: lon_weight = 32'd0;
		endcase
	endfunction

endpackage

// File: rtl/core/nmea_gga_vtg_sentence_parser.sv
// NMEA GGA/VTG sentence parser.
// Input channel s_axis_*: one ASCII byte per word in s_axis_tdata[7:0].
// Output channel m_axis_*: one result word per newline seen inside a sentence.
// The result carries the sentence kind (0 rejected, 1 GGA fix, 2 VTG,
// 3 GGA no fix) and the held position, quality, course and speed values.
// Throughput: one byte per cycle while s_axis_tready stays high. The input byte is registered, then one
// pass of decode logic updates the parser state and the result register.
// A newline byte is registered in the input register, decoded, and its result word
// is registered in the output buffer before m_axis_tvalid rises.
// Bytes that produce no result leave the output untouched.
// Reset clears the parser state and all held values to zero; the block
// waits for a '$' before decoding anything.
// When the receiver stalls, results queue in a two-word buffer; s_axis_tready
// drops while a byte sits in the input register and the output word is
// stalled, and also while the spare word is full.
module nmea_gga_vtg_sentence_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// sentence_kind[1:0], latitude_code[33:2], longitude_code[65:34],
	// quality_byte[73:66], course_hundredths[93:74], speed_hundredths[113:94], pad
	output logic [119:0] m_axis_tdata
);
	import nmea_pkg::*;

	logic v_s1;
	logic [7:0] b_s1;
	logic core_v;
	result_t core_res, out_res;
	logic buf_ready;

	// a byte in s1 produces at most one result; stop only if buffer cannot take it
	assign s_axis_tready = buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= s_axis_tvalid && s_axis_tready;
	end
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) b_s1 <= s_axis_tdata;
	end

	nmea_core u_core (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .b_s1(b_s1),
		.res_valid(core_v), .res(core_res)
	);

	// s1 holds at most one byte while buf_ready is low, so the skid never overflows
	logic skid_room;
	nmea_out_buf u_buf (
		.clk(clk), .arst_n(arst_n), .in_valid(core_v), .in_ready(skid_room),
		.in_data(core_res), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(out_res)
	);
	assign buf_ready = skid_room && !(v_s1 && m_axis_tvalid && !m_axis_tready);

	assign m_axis_tdata = {6'b0, out_res.speed, out_res.course, out_res.quality,
		out_res.lon, out_res.lat, out_res.kind};

endmodule

// File: rtl/core/nmea_core.sv
module nmea_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [7:0]              b_s1,
	output logic                    res_valid,
	output nmea_pkg::result_t       res
);
	import nmea_pkg::*;

	logic in_sentence_q;
	logic [7:0] char_pos_q, xor_q, rx_ck_q, fci_q;
	logic [1:0] hk_q, ckp_q, fds_q;
	logic [FIELD_W-1:0] fidx_q;
	logic [31:0] p_lat_q, p_lon_q, h_lat_q, h_lon_q;
	logic [7:0] p_fix_q, p_sat_q, h_q_q;
	logic [2:0] p_dop_q;
	logic [19:0] p_crs_q, p_spd_q, h_crs_q, h_spd_q;

	logic in_sentence_d;
	logic [7:0] char_pos_d, xor_d, rx_ck_d, fci_d;
	logic [1:0] hk_d, ckp_d, fds_d;
	logic [FIELD_W-1:0] fidx_d;
	logic [31:0] p_lat_d, p_lon_d, h_lat_d, h_lon_d;
	logic [7:0] p_fix_d, p_sat_d, h_q_d;
	logic [2:0] p_dop_d;
	logic [19:0] p_crs_d, p_spd_d, h_crs_d, h_spd_d;
	logic emit;
	logic [1:0] kind_d;

	logic is_dig;
	logic [3:0] dv;
	logic [3:0] hexv;
	logic hex_ok;
	logic [19:0] hund_in, hund_out;
	logic [1:0] hund_fds;
	logic [23:0] hund_sum;
	logic [11:0] sat_sum;
	logic [6:0] dop_sum;
	logic ok;
	logic [1:0] dcls, scls;

	assign is_dig = (b_s1 >= 8'h30) && (b_s1 <= 8'h39);
	assign dv = b_s1[3:0];

	always_comb begin
		hex_ok = 1'b1;
		hexv = 4'd0;
		if (is_dig) hexv = dv;
		else if (b_s1 >= 8'h41 && b_s1 <= 8'h46) hexv = 4'(b_s1 - 8'h37);
		else if (b_s1 >= 8'h61 && b_s1 <= 8'h66) hexv = 4'(b_s1 - 8'h57);
		else hex_ok = 1'b0;
	end

	// shared hundredths accumulator for course/speed
	assign hund_in = (fidx_q == FIELD_W'(1)) ? p_crs_q : p_spd_q;
	always_comb begin
		hund_fds = fds_q;
		hund_sum = {4'b0, hund_in};
		if (fds_q != NUM_END) begin
			if (is_dig) begin
				case (fds_q)
					NUM_INT: hund_sum = 24'({hund_in, 3'b0}) + 24'({hund_in, 1'b0})
						+ 24'(dv) * 24'd100;
					NUM_F1: begin
						hund_sum = {4'b0, hund_in} + 24'(dv) * 24'd10;
						hund_fds = NUM_F2;
					end
					default: begin
						hund_sum = {4'b0, hund_in} + 24'(dv);
						hund_fds = NUM_END;
					end
				endcase
			end else if (b_s1 == CH_DOT && fds_q == NUM_INT) hund_fds = NUM_F1;
			else hund_fds = NUM_END;
		end
		hund_out = (hund_sum > 24'(SAT_MAX)) ? SAT_MAX : hund_sum[19:0];
	end

	assign sat_sum = 12'({p_sat_q, 3'b0}) + 12'({p_sat_q, 1'b0}) + 12'(dv);
	assign dop_sum = 7'({p_dop_q, 3'b0}) + 7'({p_dop_q, 1'b0}) + 7'(dv);

	always_comb begin
		case (p_dop_q)
			3'd0: dcls = 2'd0;
			3'd1: dcls = 2'd1;
			3'd2, 3'd3, 3'd4: dcls = 2'd2;
			default: dcls = 2'd3;
		endcase
		if (p_sat_q >= 8'd9) scls = 2'd3;
		else if (p_sat_q >= 8'd7) scls = 2'd2;
		else if (p_sat_q >= 8'd4) scls = 2'd1;
		else scls = 2'd0;
	end

	assign ok = (hk_q == HK_GGA || hk_q == HK_VTG) && char_pos_q >= 8'd6
		&& ckp_q == CK_DONE && xor_q == rx_ck_q;

	always_comb begin
		in_sentence_d = in_sentence_q; char_pos_d = char_pos_q; hk_d = hk_q;
		xor_d = xor_q; ckp_d = ckp_q; rx_ck_d = rx_ck_q; fidx_d = fidx_q;
		fci_d = fci_q; fds_d = fds_q;
		p_lat_d = p_lat_q; p_lon_d = p_lon_q; p_fix_d = p_fix_q; p_sat_d = p_sat_q;
		p_dop_d = p_dop_q; p_crs_d = p_crs_q; p_spd_d = p_spd_q;
		h_lat_d = h_lat_q; h_lon_d = h_lon_q; h_q_d = h_q_q;
		h_crs_d = h_crs_q; h_spd_d = h_spd_q;
		emit = 1'b0; kind_d = KIND_REJ;
		if (!in_valid) begin
		end else if (b_s1 == CH_DOLLAR) begin
			in_sentence_d = 1'b1; char_pos_d = 8'd1; hk_d = HK_MATCH;
			xor_d = '0; ckp_d = CK_ACC; rx_ck_d = '0; fidx_d = '0; fci_d = '0;
			fds_d = NUM_INT; p_lat_d = '0; p_lon_d = '0; p_fix_d = '0; p_sat_d = '0;
			p_dop_d = '0; p_crs_d = '0; p_spd_d = '0;
		end else if (!in_sentence_q) begin
		end else if (b_s1 == CH_NL) begin
			emit = 1'b1;
			in_sentence_d = 1'b0;
			if (ok && hk_q == HK_GGA) begin
				h_lat_d = p_lat_q; h_lon_d = p_lon_q;
				h_q_d = {dcls, scls, 4'b0};
				kind_d = (p_fix_q == 8'h31 || p_fix_q == 8'h32) ? KIND_FIX : KIND_NOFIX;
			end else if (ok) begin
				h_crs_d = p_crs_q; h_spd_d = p_spd_q;
				kind_d = KIND_VTG;
			end
		end else begin
			case (char_pos_q)
				8'd1: if (hk_q != HK_MATCH || b_s1 != 8'h47) hk_d = HK_NONE;
				8'd2: if (hk_q != HK_MATCH || b_s1 != 8'h50) hk_d = HK_NONE;
				8'd3: begin
					if (hk_q == HK_MATCH && b_s1 == 8'h47) hk_d = HK_GGA;
					else if (hk_q == HK_MATCH && b_s1 == 8'h56) hk_d = HK_VTG;
					else hk_d = HK_NONE;
				end
				8'd4: begin
					if (hk_q == HK_GGA) begin
						if (b_s1 != 8'h47) hk_d = HK_NONE;
					end else if (hk_q == HK_VTG) begin
						if (b_s1 != 8'h54) hk_d = HK_NONE;
					end else hk_d = HK_NONE;
				end
				8'd5: begin
					if (hk_q == HK_GGA) begin
						if (b_s1 != 8'h41) hk_d = HK_NONE;
					end else if (hk_q == HK_VTG) begin
						if (b_s1 != 8'h47) hk_d = HK_NONE;
					end else hk_d = HK_NONE;
				end
				default: ;
			endcase
			if (char_pos_q != 8'hFF) char_pos_d = char_pos_q + 8'd1;
			if (ckp_q == CK_ACC) begin
				if (b_s1 == CH_STAR) ckp_d = CK_HI;
				else begin
					xor_d = xor_q ^ b_s1;
					if (b_s1 == CH_COMMA) begin
						if (fidx_q != FIELD_W'(MAX_FIELDS - 1)) fidx_d = fidx_q + 1'b1;
						fci_d = '0;
						fds_d = NUM_INT;
					end else begin
						// hk_q here is already final for fields past the header
						if (hk_q == HK_GGA) begin
							case (fidx_q)
								FIELD_W'(2): if (is_dig)
									p_lat_d = p_lat_q + lat_weight(fci_q) * 32'(dv);
								FIELD_W'(3): if (fci_q == 8'd0 && b_s1 == 8'h53)
									p_lat_d = p_lat_q | 32'h80000000;
								FIELD_W'(4): if (is_dig)
									p_lon_d = p_lon_q + lon_weight(fci_q) * 32'(dv);
								FIELD_W'(5): if (fci_q == 8'd0 && b_s1 == 8'h57)
									p_lon_d = p_lon_q | 32'h80000000;
								FIELD_W'(6): if (fci_q == 8'd0) p_fix_d = b_s1;
								FIELD_W'(7): if (fds_q != NUM_END) begin
									if (!is_dig) fds_d = NUM_END;
									else p_sat_d = (sat_sum > 12'd255) ? 8'd255 : sat_sum[7:0];
								end
								FIELD_W'(8): if (fds_q != NUM_END) begin
									if (!is_dig) fds_d = NUM_END;
									else p_dop_d = (dop_sum > 7'd7) ? 3'd7 : dop_sum[2:0];
								end
								default: ;
							endcase
						end else if (hk_q == HK_VTG) begin
							if (fidx_q == FIELD_W'(1)) begin
								p_crs_d = hund_out; fds_d = hund_fds;
							end else if (fidx_q == FIELD_W'(7)) begin
								p_spd_d = hund_out; fds_d = hund_fds;
							end
						end
						if (fci_q != 8'hFF) fci_d = fci_q + 8'd1;
					end
				end
			end else if (ckp_q == CK_HI || ckp_q == CK_LO) begin
				if (!hex_ok) begin
					hk_d = HK_NONE; ckp_d = CK_DONE;
				end else if (ckp_q == CK_HI) begin
					rx_ck_d = {hexv, 4'b0}; ckp_d = CK_LO;
				end else begin
					rx_ck_d = rx_ck_q | {4'b0, hexv}; ckp_d = CK_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0; char_pos_q <= '0; hk_q <= HK_NONE; xor_q <= '0;
			ckp_q <= CK_ACC; rx_ck_q <= '0; fidx_q <= '0; fci_q <= '0; fds_q <= NUM_INT;
			p_lat_q <= '0; p_lon_q <= '0; p_fix_q <= '0; p_sat_q <= '0; p_dop_q <= '0;
			p_crs_q <= '0; p_spd_q <= '0; h_lat_q <= '0; h_lon_q <= '0; h_q_q <= '0;
			h_crs_q <= '0; h_spd_q <= '0;
		end else begin
			in_sentence_q <= in_sentence_d; char_pos_q <= char_pos_d; hk_q <= hk_d;
			xor_q <= xor_d; ckp_q <= ckp_d; rx_ck_q <= rx_ck_d; fidx_q <= fidx_d;
			fci_q <= fci_d; fds_q <= fds_d; p_lat_q <= p_lat_d; p_lon_q <= p_lon_d;
			p_fix_q <= p_fix_d; p_sat_q <= p_sat_d; p_dop_q <= p_dop_d;
			p_crs_q <= p_crs_d; p_spd_q <= p_spd_d; h_lat_q <= h_lat_d;
			h_lon_q <= h_lon_d; h_q_q <= h_q_d; h_crs_q <= h_crs_d; h_spd_q <= h_spd_d;
		end
	end

	assign res_valid = emit;
	assign res = '{kind: kind_d, lat: h_lat_d, lon: h_lon_d, quality: h_q_d,
		course: h_crs_d, speed: h_spd_d};

endmodule

// File: rtl/core/nmea_out_buf.sv
module nmea_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nmea_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output nmea_pkg::result_t out_data
);
	import nmea_pkg::*;

	// two-entry skid: main output register plus one spare
	logic main_v_q, skid_v_q;
	result_t main_q, skid_q;

	assign in_ready = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || out_ready) begin
				main_v_q <= skid_v_q || in_valid;
				skid_v_q <= 1'b0;
			end else if (in_valid) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_q <= skid_v_q ? skid_q : in_data;
		end else if (in_valid && !skid_v_q) begin
			skid_q <= in_data;
		end
	end

endmodule

// File: rtl/core/nmea_checker.sv
module nmea_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [7:0]   s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [119:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[119:114] == 6'd0 && m_axis_tdata[69:66] == 4'd0)
		else $error("reserved bits set");
	a_nonl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tvalid && s_axis_tready && s_axis_tdata == 8'h0A) ##1
		!m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result without newline");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
endmodule

bind nmea_gga_vtg_sentence_parser nmea_checker u_nmea_checker (.*);

// File: test/tb_nmea_gga_vtg_sentence_parser.sv
module tb_nmea_gga_vtg_sentence_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import nmea_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // rx_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// sentence_kind[1:0], latitude_code[33:2], longitude_code[65:34],
	// quality_byte[73:66], course_hundredths[93:74], speed_hundredths[113:94], pad
	logic [119:0] m_axis_tdata;

	nmea_gga_vtg_sentence_parser dut (.*);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// parser mirror state
	logic        p_in, p_done;
	logic [7:0]  p_pos, p_xor, p_rcv, p_fci, p_fix, p_sat;
	logic [1:0]  p_hk, p_ck, p_frac;
	logic [3:0]  p_fld;
	logic [31:0] p_lat, p_lon, h_lat, h_lon;
	logic [2:0]  p_dop;
	logic [19:0] p_crs, p_spd, h_crs, h_spd;
	logic [7:0]  h_q;

	result_t     sentence_results[$];
	int          errors;
	int          send_idle_pct, recv_idle_pct;
	int          hold_off_cycles;
	longint      cycle_count;

	function automatic bit is_dig(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic int hexv(logic [7:0] b);
		if (is_dig(b)) return b - 8'h30;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		if (b >= "a" && b <= "f") return b - "a" + 10;
		return -1;
	endfunction

	function automatic logic [31:0] lat_w(int k);
		case (k)
			0: return 10000000; 1: return 1000000; 2: return 100000; 3: return 10000;
			5: return 1000; 6: return 100; 7: return 10; 8: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic [31:0] lon_w(int k);
		case (k)
			0: return 100000000; 1: return 10000000; 2: return 1000000; 3: return 100000;
			4: return 10000; 6: return 1000; 7: return 100; 8: return 10; 9: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic [19:0] hundredths(logic [19:0] v, logic [7:0] b);
		longint r;
		r = v;
		if (p_frac == NUM_END) return v;
		if (is_dig(b)) begin
			if (p_frac == NUM_INT) r = r * 10 + (b - 8'h30) * 100;
			else if (p_frac == NUM_F1) begin
				r += (b - 8'h30) * 10;
				p_frac = NUM_F2;
			end else begin
				r += b - 8'h30;
				p_frac = NUM_END;
			end
		end else if (b == CH_DOT && p_frac == NUM_INT) begin
			p_frac = NUM_F1;
		end else begin
			p_frac = NUM_END;
		end
		return r > SAT_MAX ? SAT_MAX : r[19:0];
	endfunction

	function automatic int sat_int(int v, logic [7:0] b, int lim);
		int r;
		if (p_frac == NUM_END) return v;
		if (!is_dig(b)) begin
			p_frac = NUM_END;
			return v;
		end
		r = v * 10 + (b - 8'h30);
		return r > lim ? lim : r;
	endfunction

	task automatic field_char(logic [7:0] b);
		int k;
		k = p_fci;
		if (p_hk == HK_GGA) begin
			case (p_fld)
				2: if (k < 9 && is_dig(b)) p_lat += lat_w(k) * (b - 8'h30);
				3: if (k == 0 && b == "S") p_lat |= 32'h80000000;
				4: if (k < 10 && is_dig(b)) p_lon += lon_w(k) * (b - 8'h30);
				5: if (k == 0 && b == "W") p_lon |= 32'h80000000;
				6: if (k == 0) p_fix = b;
				7: p_sat = sat_int(p_sat, b, 255);
				8: p_dop = sat_int(p_dop, b, 7);
				default: ;
			endcase
		end else if (p_hk == HK_VTG) begin
			if (p_fld == 1) p_crs = hundredths(p_crs, b);
			else if (p_fld == 7) p_spd = hundredths(p_spd, b);
		end
		if (p_fci < 255) p_fci++;
	endtask

	task automatic begin_sentence();
		p_in = 1; p_pos = 1; p_hk = HK_MATCH; p_xor = 0; p_ck = CK_ACC; p_rcv = 0;
		p_fld = 0; p_fci = 0; p_frac = NUM_INT; p_lat = 0; p_lon = 0; p_fix = 0;
		p_sat = 0; p_dop = 0; p_crs = 0; p_spd = 0;
	endtask

	task automatic match_header(logic [7:0] b);
		logic [7:0] want;
		if (p_pos == 1 || p_pos == 2) begin
			if (p_hk != HK_MATCH || b != (p_pos == 1 ? "G" : "P")) p_hk = HK_NONE;
		end else if (p_pos == 3) begin
			if (p_hk == HK_MATCH && b == "G") p_hk = HK_GGA;
			else if (p_hk == HK_MATCH && b == "V") p_hk = HK_VTG;
			else p_hk = HK_NONE;
		end else if (p_pos == 4 || p_pos == 5) begin
			if (p_hk == HK_GGA) want = p_pos == 4 ? "G" : "A";
			else if (p_hk == HK_VTG) want = p_pos == 4 ? "T" : "G";
			else begin
				p_hk = HK_NONE;
				return;
			end
			if (b != want) p_hk = HK_NONE;
		end
	endtask

	task automatic parse_byte(logic [7:0] b);
		bit ok;
		int h;
		result_t r;
		if (b == CH_DOLLAR) begin
			begin_sentence();
			return;
		end
		if (!p_in) return;
		if (b == CH_NL) begin
			ok = (p_hk == HK_GGA || p_hk == HK_VTG) && p_pos >= 6 && p_ck == CK_DONE
				&& p_xor == p_rcv;
			r.kind = KIND_REJ;
			if (ok && p_hk == HK_GGA) begin
				h_q = p_dop == 0 ? 8'h00 : p_dop == 1 ? 8'h40 : p_dop < 5 ? 8'h80 : 8'hC0;
				if (p_sat >= 9) h_q |= 8'h30;
				else if (p_sat >= 7) h_q |= 8'h20;
				else if (p_sat >= 4) h_q |= 8'h10;
				h_lat = p_lat;
				h_lon = p_lon;
				r.kind = (p_fix == "1" || p_fix == "2") ? KIND_FIX : KIND_NOFIX;
			end else if (ok) begin
				h_crs = p_crs;
				h_spd = p_spd;
				r.kind = KIND_VTG;
			end
			p_in = 0;
			r.lat = h_lat; r.lon = h_lon; r.quality = h_q; r.course = h_crs; r.speed = h_spd;
			sentence_results.push_back(r);
			return;
		end
		match_header(b);
		if (p_pos < 255) p_pos++;
		if (p_ck == CK_ACC) begin
			if (b == CH_STAR) begin
				p_ck = CK_HI;
				return;
			end
			p_xor ^= b;
			if (b == CH_COMMA) begin
				if (p_fld < MAX_FIELDS - 1) p_fld++;
				p_fci = 0;
				p_frac = NUM_INT;
			end else begin
				field_char(b);
			end
		end else if (p_ck != CK_DONE) begin
			h = hexv(b);
			if (h < 0) begin
				p_hk = HK_NONE;
				p_ck = CK_DONE;
			end else if (p_ck == CK_HI) begin
				p_rcv = h << 4;
				p_ck = CK_LO;
			end else begin
				p_rcv |= h;
				p_ck = CK_DONE;
			end
		end
	endtask

	// entered at a falling edge; tready is settled between the falling and rising edges
	task automatic send_byte(logic [7:0] b);
		bit taken;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		taken = 1'b0;
		while (!taken) begin
			#1;
			taken = s_axis_tready;
			@(posedge clk);
			if (!taken) @(negedge clk);
		end
		parse_byte(b);
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	function automatic string hex2(logic [7:0] v);
		return $sformatf("%02X", v);
	endfunction

	// wraps a body in $...*CS\r\n, optionally with a corrupted or lowercase checksum
	task automatic send_sentence(string body, bit bad_sum = 0, bit lower = 0);
		logic [7:0] x;
		string cs;
		x = 0;
		foreach (body[i]) x ^= body[i];
		if (bad_sum) x ^= 8'h01 << $urandom_range(7);
		cs = hex2(x);
		if (lower) cs = cs.tolower();
		send_text({"$", body, "*", cs, "\r\n"});
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sentence_results.size() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tdata[1:0];
			got.lat = m_axis_tdata[33:2];
			got.lon = m_axis_tdata[65:34];
			got.quality = m_axis_tdata[73:66];
			got.course = m_axis_tdata[93:74];
			got.speed = m_axis_tdata[113:94];
			if (sentence_results.size() == 0) begin
				$error("unexpected result word %h", m_axis_tdata);
				errors++;
			end else begin
				want = sentence_results.pop_front();
				if (got.kind != want.kind) begin
					$error("sentence_kind exp %0d got %0d", want.kind, got.kind); errors++;
				end
				if (got.lat != want.lat) begin
					$error("latitude_code exp %h got %h", want.lat, got.lat); errors++;
				end
				if (got.lon != want.lon) begin
					$error("longitude_code exp %h got %h", want.lon, got.lon); errors++;
				end
				if (got.quality != want.quality) begin
					$error("quality_byte exp %h got %h", want.quality, got.quality); errors++;
				end
				if (got.course != want.course) begin
					$error("course_hundredths exp %0d got %0d", want.course, got.course);
					errors++;
				end
				if (got.speed != want.speed) begin
					$error("speed_hundredths exp %0d got %0d", want.speed, got.speed);
					errors++;
				end
			end
		end
	end

	// receiver stall generator
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic string rand_digits(int n);
		string s;
		s = "";
		repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
		return s;
	endfunction

	function automatic string rand_gga();
		string ns, ew;
		if ($urandom_range(1)) ns = "S";
		else ns = "N";
		if ($urandom_range(1)) ew = "W";
		else ew = "E";
		return {"GPGGA,", rand_digits(6), ".00,",
			rand_digits(4), ".", rand_digits($urandom_range(1, 5)), ",", ns, ",",
			rand_digits(5), ".", rand_digits($urandom_range(0, 5)), ",", ew, ",",
			$sformatf("%0d", $urandom_range(3)), ",",
			rand_digits($urandom_range(0, 3)), ",",
			rand_digits($urandom_range(0, 2)), ".", rand_digits(1), ",545.4,M,46.9,M,,"};
	endfunction

	function automatic string rand_vtg();
		return {"GPVTG,", rand_digits($urandom_range(0, 4)), ".", rand_digits($urandom_range(0, 3)),
			",T,,M,", rand_digits(2), ".", rand_digits(1), ",N,",
			rand_digits($urandom_range(0, 7)), ".", rand_digits($urandom_range(0, 3)), ",K"};
	endfunction

	task automatic test_directed();
		send_text("junk\n");
		send_sentence("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,");
		send_sentence("GPGGA,1,9999.9999,S,99999.9999,W,2,99,7.5", 0, 1);
		send_sentence("GPGGA,,,,,,0,,");
		send_sentence("GPGGA,x,48a7.0x8,S,0b1-1.0,W,6,4,1");
		send_sentence("GPGGA,,1,N,1,E,1,07,2");
		send_sentence("GPVTG,054.7,T,034.4,M,005.5,N,010.2,K");
		send_sentence("GPVTG,9999999.99,T,,,,,99999999,K");
		send_sentence("GPVTG,1.234,T,,,,,-5.0,K");
		send_sentence("GPVTG,12.3,T,,,,,4.56,K", 1);
		send_sentence("GPRMC,1,2,3");
		send_text("$GPGGA,1,2*\r\n");
		send_text("$GPVTG,1*4G\r\n");
		send_text("$GPVTG*\n");
		send_text("$GPVT\n");
		send_text("$GPGGA,11,$GPVTG,5.0,T,,,,,,,,,,,,,,,,,,,1,*00xyz\n");
		send_text("$\n");
		send_byte(8'hFF);
		send_byte(8'h00);
		drain();
	endtask

	task automatic test_random(int n_bytes);
		int sent, k;
		string s, tail;
		sent = 0;
		while (sent < n_bytes) begin
			k = $urandom_range(99);
			if (k < 40) s = rand_gga();
			else if (k < 75) s = rand_vtg();
			else s = "";
			if (k < 70) begin
				send_sentence(s, $urandom_range(9) == 0, $urandom_range(1));
				sent += s.len() + 6;
			end else if (k < 80) begin
				// broken sentence: truncated, with or without a closing newline
				if (s.len() == 0) s = rand_gga();
				s = s.substr(0, $urandom_range(s.len() - 1));
				tail = "";
				if ($urandom_range(1)) tail = "\n";
				send_text({"$", s, tail});
				sent += s.len() + 2;
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_byte(8'($urandom_range(255)));
					sent++;
				end
				send_byte(CH_NL);
				sent++;
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_off_cycles = 400;
		repeat (6) send_sentence("GPVTG,1.0,T,,,,,2.0,K");
		drain();
	endtask

	initial begin
		errors = 0;
		cycle_count = 0;
		hold_off_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		m_axis_tready = 1'b0;
		p_in = 0; p_pos = 0; p_hk = HK_NONE; p_xor = 0; p_ck = CK_ACC; p_rcv = 0;
		p_fld = 0; p_fci = 0; p_frac = NUM_INT; p_lat = 0; p_lon = 0; p_fix = 0;
		p_sat = 0; p_dop = 0; p_crs = 0; p_spd = 0;
		h_lat = 0; h_lon = 0; h_q = 0; h_crs = 0; h_spd = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		send_idle_pct = 29; recv_idle_pct = 67;
		test_random(120);
		send_idle_pct = 67; recv_idle_pct = 29;
		test_random(120);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(120);
		repeat (10) @(negedge clk);
		if (errors == 0 && sentence_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
